@@ rtl/cfd_pkg.sv @@
// ----------------------------------------------------------------------------
// Command frame deframer package
// Shared constants, codes and types of the command frame deframer.
// ----------------------------------------------------------------------------
package cfd_pkg;

   localparam int MSG_DEPTH   = 256;
   localparam int MSG_AW      = $clog2(MSG_DEPTH);
   localparam int DEFAULT_LEN = 16;

   localparam logic [7:0] FRAME_DELIM   = 8'hFE;
   localparam logic [7:0] CHECK_BASE    = 8'hFF;
   localparam logic [7:0] ERR_CHECK     = 8'hAA;
   localparam logic [7:0] ERR_DELIM     = 8'hAB;
   localparam logic [7:0] ERR_ACTION    = 8'hAC;
   localparam logic [7:0] ACT_TEXT      = 8'h01;
   localparam logic [7:0] ACT_COLOUR    = 8'h02;
   localparam logic [7:0] ACT_DEFAULT   = 8'h03;
   localparam logic [7:0] RED_RESET     = 8'h0C;
   localparam logic [7:0] SEQ_ACK_TAG   = 8'h01;
   localparam logic [7:0] SEQ_ERR_TAG   = 8'h02;
   localparam logic [7:0] SEQ_TAIL      = 8'h01;
   localparam logic [7:0] COLOUR_COUNT  = 8'd3;

   typedef enum logic [2:0] {
      PH_DELIM,
      PH_LENGTH,
      PH_ACTION,
      PH_PAYLOAD,
      PH_CHECK
   } phase_type;

   typedef enum logic {
      RESP_ACK,
      RESP_ERR
   } resp_kind_type;

   localparam logic [2:0] ACK_LAST_IDX = 3'd2;
   localparam logic [2:0] ERR_LAST_IDX = 3'd4;

   typedef struct packed {
      resp_kind_type kind;
      logic [7:0]    code;
      logic [7:0]    detail;
      logic [7:0]    length;
      logic [7:0]    red;
      logic [7:0]    green;
      logic [7:0]    blue;
   } resp_slot_type;

   typedef struct packed {
      logic          start;
      resp_slot_type slot;
   } resp_req_type;

endpackage

@@ rtl/cfd_req_if.sv @@
// ----------------------------------------------------------------------------
// Received byte channel
// Carries one received byte per item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ rtl/cfd_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Response byte channel
// Carries one response byte per item with the display status alongside.
// ----------------------------------------------------------------------------
interface cfd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       tx_last;
   logic       restart_display;
   logic [7:0] msg_length;
   logic [7:0] red_level;
   logic [7:0] green_level;
   logic [7:0] blue_level;

   modport source (output valid, output tx_byte, output tx_last, output restart_display,
                   output msg_length, output red_level, output green_level,
                   output blue_level, input ready);
   modport sink   (input valid, input tx_byte, input tx_last, input restart_display,
                   input msg_length, input red_level, input green_level,
                   input blue_level, output ready);
endinterface

@@ rtl/cfd_responder.sv @@
// ----------------------------------------------------------------------------
// Command frame deframer responder
// Holds an active and a pending response sequence and sends it byte by byte.
// ----------------------------------------------------------------------------
module cfd_responder
   import cfd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  resp_req_type start_req,
   output logic         accept_ok,
   cfd_rsp_if.source    rsp
);

   logic          act_valid_ff, act_valid_in;
   logic          pend_valid_ff, pend_valid_in;
   resp_slot_type act_ff, act_in;
   resp_slot_type pend_ff, pend_in;
   logic [2:0]    idx_ff, idx_in;
   logic          last_byte;
   logic          finishing;

   assign last_byte = (act_ff.kind == RESP_ACK) ? (idx_ff == ACK_LAST_IDX)
                                                : (idx_ff == ERR_LAST_IDX);
   assign finishing = act_valid_ff && rsp.ready && last_byte;
   assign accept_ok = !pend_valid_ff;

   always_comb begin
      act_valid_in  = act_valid_ff;
      pend_valid_in = pend_valid_ff;
      act_in        = act_ff;
      pend_in       = pend_ff;
      idx_in        = idx_ff;
      if (act_valid_ff && rsp.ready) begin
         if (last_byte) begin
            act_valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
      if (finishing && pend_valid_ff) begin
         act_valid_in  = 1'b1;
         act_in        = pend_ff;
         idx_in        = 3'd0;
         pend_valid_in = 1'b0;
      end
      if (start_req.start) begin
         if (!act_valid_ff || finishing) begin
            act_valid_in = 1'b1;
            act_in       = start_req.slot;
            idx_in       = 3'd0;
         end else begin
            pend_valid_in = 1'b1;
            pend_in       = start_req.slot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         idx_ff        <= 3'd0;
      end else begin
         act_valid_ff  <= act_valid_in;
         pend_valid_ff <= pend_valid_in;
         idx_ff        <= idx_in;
      end
      act_ff  <= act_in;
      pend_ff <= pend_in;
   end

   always_comb begin
      unique case (idx_ff)
         3'd0:    rsp.tx_byte = FRAME_DELIM;
         3'd1:    rsp.tx_byte = (act_ff.kind == RESP_ACK) ? SEQ_ACK_TAG : SEQ_ERR_TAG;
         3'd2:    rsp.tx_byte = (act_ff.kind == RESP_ACK) ? SEQ_TAIL : act_ff.code;
         3'd3:    rsp.tx_byte = act_ff.detail;
         3'd4:    rsp.tx_byte = SEQ_TAIL;
         default: rsp.tx_byte = SEQ_TAIL;
      endcase
   end

   assign rsp.valid           = act_valid_ff;
   assign rsp.tx_last         = last_byte;
   assign rsp.restart_display = (act_ff.kind == RESP_ERR);
   assign rsp.msg_length      = act_ff.length;
   assign rsp.red_level       = act_ff.red;
   assign rsp.green_level     = act_ff.green;
   assign rsp.blue_level      = act_ff.blue;

   // A sequence is only queued behind one that is being sent.
   assert property (@(posedge clock) disable iff (reset) pend_valid_ff |-> act_valid_ff)
      else $error("pending response without active response");

   assert property (@(posedge clock) disable iff (reset) start_req.start |-> !pend_valid_ff)
      else $error("response started while the queue is full");

   assert property (@(posedge clock) disable iff (reset)
                    (act_valid_ff && act_ff.kind == RESP_ACK) |-> (idx_ff <= ACK_LAST_IDX))
      else $error("acknowledge index out of range");

   assert property (@(posedge clock) disable iff (reset)
                    act_valid_ff |-> (idx_ff <= ERR_LAST_IDX))
      else $error("response index out of range");

endmodule

@@ rtl/command_frame_deframer_top.sv @@
// ----------------------------------------------------------------------------
// Command frame deframer
// Parses 0xFE, length, action, payload, check frames and answers each one.
// ----------------------------------------------------------------------------
// The req channel takes one received byte per item. The rsp channel gives one
// response byte per item: an acknowledge sequence of three items after a good
// check byte, or an error sequence of five items after a bad delimiter, an
// unknown action or a bad check. Every response item also carries the message
// length and the colour levels as they stand after the frame.
// A byte is parsed in the cycle it is accepted; its response sequence is
// registered and its items follow one per cycle while rsp.ready is high.
// Bytes that finish no frame are taken one per cycle while req.ready is high.
// Two response sequences can be held: one being sent and one waiting. While a
// sequence waits, req.ready is low, so a stalled receiver backs up the byte
// stream after at most one more completed frame.
// Text payload bytes are written to a message memory with one write port.
// Reset returns the parser to waiting for a delimiter, the message length to
// the default, the colour to the default red, and drops any queued response.
// ----------------------------------------------------------------------------
module command_frame_deframer_top
   import cfd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   cfd_req_if.sink   req,
   cfd_rsp_if.source rsp
);

   phase_type    phase_ff, phase_in;
   logic [7:0]   length_ff, length_in;
   logic [7:0]   action_ff, action_in;
   logic [7:0]   sum_ff, sum_in;
   logic [7:0]   index_ff, index_in;
   logic [7:0]   cur_len_ff, cur_len_in;
   logic [7:0]   red_ff, red_in;
   logic [7:0]   green_ff, green_in;
   logic [7:0]   blue_ff, blue_in;
   logic [7:0]   msg_mem [MSG_DEPTH];
   logic         mem_we;
   logic         accept_ok;
   logic         fire;
   logic [7:0]   b;
   logic [7:0]   want;
   logic [7:0]   text_count;
   logic [7:0]   pay_count;
   logic [7:0]   index_inc;
   resp_req_type start_req;

   assign req.ready  = accept_ok;
   assign fire       = req.valid && req.ready;
   assign b          = req.rx_byte;
   assign want       = CHECK_BASE - sum_ff;
   assign text_count = (length_ff == 8'd0) ? 8'd0 : length_ff - 8'd1;
   assign pay_count  = (action_ff == ACT_COLOUR) ? COLOUR_COUNT : text_count;
   assign index_inc  = index_ff + 8'd1;

   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         unique case (phase_ff)
            PH_DELIM:   phase_in = (b == FRAME_DELIM) ? PH_LENGTH : PH_DELIM;
            PH_LENGTH:  phase_in = PH_ACTION;
            PH_ACTION: begin
               if (b == ACT_DEFAULT) begin
                  phase_in = PH_CHECK;
               end else if (b == ACT_COLOUR) begin
                  phase_in = PH_PAYLOAD;
               end else if (b == ACT_TEXT) begin
                  phase_in = (length_ff <= 8'd1) ? PH_CHECK : PH_PAYLOAD;
               end else begin
                  phase_in = PH_DELIM;
               end
            end
            PH_PAYLOAD: phase_in = (index_inc >= pay_count) ? PH_CHECK : PH_PAYLOAD;
            PH_CHECK:   phase_in = PH_DELIM;
            default:    phase_in = PH_DELIM;
         endcase
      end
   end

   always_comb begin
      length_in  = length_ff;
      action_in  = action_ff;
      sum_in     = sum_ff;
      index_in   = index_ff;
      cur_len_in = cur_len_ff;
      red_in     = red_ff;
      green_in   = green_ff;
      blue_in    = blue_ff;
      mem_we     = 1'b0;
      start_req  = '0;
      if (fire) begin
         unique case (phase_ff)
            PH_DELIM: begin
               if (b != FRAME_DELIM) begin
                  cur_len_in            = 8'(DEFAULT_LEN);
                  start_req.start       = 1'b1;
                  start_req.slot.kind   = RESP_ERR;
                  start_req.slot.code   = ERR_DELIM;
                  start_req.slot.detail = 8'd0;
               end
            end
            PH_LENGTH: begin
               length_in = b;
            end
            PH_ACTION: begin
               action_in = b;
               index_in  = 8'd0;
               sum_in    = b;
               if (b == ACT_DEFAULT) begin
                  cur_len_in = 8'(DEFAULT_LEN);
               end else if (b == ACT_TEXT) begin
                  if (length_ff <= 8'd1) begin
                     cur_len_in = 8'd0;
                  end
               end else if (b != ACT_COLOUR) begin
                  cur_len_in            = 8'(DEFAULT_LEN);
                  start_req.start       = 1'b1;
                  start_req.slot.kind   = RESP_ERR;
                  start_req.slot.code   = ERR_ACTION;
                  start_req.slot.detail = b;
               end
            end
            PH_PAYLOAD: begin
               sum_in   = sum_ff + b;
               index_in = index_inc;
               if (action_ff == ACT_COLOUR) begin
                  if (index_ff == 8'd0) begin
                     red_in = b;
                  end else if (index_ff == 8'd1) begin
                     green_in = b;
                  end else begin
                     blue_in = b;
                  end
               end else begin
                  mem_we = ({1'b0, index_ff} < 9'(MSG_DEPTH));
                  if (index_inc >= pay_count) begin
                     cur_len_in = index_inc;
                  end
               end
            end
            PH_CHECK: begin
               start_req.start = 1'b1;
               if (b == want) begin
                  start_req.slot.kind = RESP_ACK;
               end else begin
                  cur_len_in            = 8'(DEFAULT_LEN);
                  start_req.slot.kind   = RESP_ERR;
                  start_req.slot.code   = ERR_CHECK;
                  start_req.slot.detail = want;
               end
            end
            default: begin
            end
         endcase
      end
      start_req.slot.length = cur_len_in;
      start_req.slot.red    = red_in;
      start_req.slot.green  = green_in;
      start_req.slot.blue   = blue_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_DELIM;
         length_ff  <= 8'd0;
         action_ff  <= 8'd0;
         sum_ff     <= 8'd0;
         index_ff   <= 8'd0;
         cur_len_ff <= 8'(DEFAULT_LEN);
         red_ff     <= RED_RESET;
         green_ff   <= 8'd0;
         blue_ff    <= 8'd0;
      end else begin
         phase_ff   <= phase_in;
         length_ff  <= length_in;
         action_ff  <= action_in;
         sum_ff     <= sum_in;
         index_ff   <= index_in;
         cur_len_ff <= cur_len_in;
         red_ff     <= red_in;
         green_ff   <= green_in;
         blue_ff    <= blue_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         msg_mem[index_ff[MSG_AW-1:0]] <= b;
      end
   end

   cfd_responder u_responder (
      .clock     (clock),
      .reset     (reset),
      .start_req (start_req),
      .accept_ok (accept_ok),
      .rsp       (rsp)
   );

   // A response only starts on an accepted byte in a phase that can end a frame.
   assert property (@(posedge clock) disable iff (reset)
                    start_req.start |-> (fire && (phase_ff == PH_DELIM
                                                  || phase_ff == PH_ACTION
                                                  || phase_ff == PH_CHECK)))
      else $error("response started outside a frame end");

   assert property (@(posedge clock) disable iff (reset)
                    (phase_ff == PH_PAYLOAD && action_ff == ACT_COLOUR) |-> (index_ff < COLOUR_COUNT))
      else $error("colour payload index out of range");

   assert property (@(posedge clock) disable iff (reset)
                    (fire && phase_ff == PH_CHECK) |=> (phase_ff == PH_DELIM))
      else $error("parser did not return to delimiter after check byte");

endmodule
